// ===== hw/rtl/pulse_width_speed_meter_macros.svh =====
// Assertion macros used by pwsm_ctrl. They sample on clk and are
// disabled while rst_n is low.
`ifndef PULSE_WIDTH_SPEED_METER_MACROS_SVH
`define PULSE_WIDTH_SPEED_METER_MACROS_SVH

`define PWSM_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("pwsm assertion failed");

`define PWSM_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("pwsm assertion failed");

`endif

// ===== hw/rtl/pwsm_pkg.sv =====
package pwsm_pkg;

  localparam int unsigned TimeoutW = 16;
  localparam int unsigned SpeedW   = 32;
  localparam int unsigned DivCntW  = 5;

  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd5000;
  localparam logic [SpeedW-1:0]   NumerReset   = 32'd4000000;
  localparam logic [TimeoutW-1:0] ElapsedMax   = 16'hFFFF;

  localparam logic CfgTimeout = 1'b0;
  localparam logic CfgNumer   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT_LOW,
    S_WAIT_HIGH,
    S_MEASURE,
    S_DIV
  } state_t;

  typedef enum logic [1:0] {
    EL_HOLD,
    EL_CLEAR,
    EL_INC,
    EL_ONE
  } el_op_t;

  typedef struct packed {
    el_op_t el_op;
    logic   div_start;
    logic   push_timeout;
    logic   push_div;
  } ctl_cmd_t;

  typedef struct packed {
    logic ge_inc;
    logic ge_one;
    logic div_done;
    logic q_room;
  } ctl_sts_t;

endpackage

// ===== hw/rtl/pwsm_ctrl.sv =====
`include "pulse_width_speed_meter_macros.svh"

module pwsm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              start_req,
  input  logic              feedback_level,
  input  pwsm_pkg::ctl_sts_t sts,
  output pwsm_pkg::ctl_cmd_t cmd
);
  import pwsm_pkg::*;

  state_t st_r;
  state_t st_nxt;
  logic   acc;

  assign in_tready = (st_r != S_DIV) && sts.q_room;
  assign acc       = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    if (acc) begin
      if (start_req) begin
        st_nxt = S_WAIT_LOW;
      end else begin
        unique case (st_r)
          S_WAIT_LOW: begin
            if (sts.ge_inc) begin
              st_nxt = S_IDLE;
            end else if (!feedback_level) begin
              st_nxt = S_WAIT_HIGH;
            end
          end
          S_WAIT_HIGH: begin
            if (sts.ge_inc) begin
              st_nxt = S_IDLE;
            end else if (feedback_level) begin
              st_nxt = sts.ge_one ? S_IDLE : S_MEASURE;
            end
          end
          S_MEASURE: begin
            if (!feedback_level) begin
              st_nxt = S_DIV;
            end else if (sts.ge_inc) begin
              st_nxt = S_IDLE;
            end
          end
          default: st_nxt = st_r;
        endcase
      end
    end else if (st_r == S_DIV && sts.div_done && sts.q_room) begin
      st_nxt = S_IDLE;
    end
  end

  always_comb begin
    cmd = '{el_op: EL_HOLD, div_start: 1'b0, push_timeout: 1'b0, push_div: 1'b0};
    if (acc) begin
      if (start_req) begin
        cmd.el_op = EL_CLEAR;
      end else begin
        unique case (st_r)
          S_WAIT_LOW: begin
            if (sts.ge_inc) begin
              cmd.push_timeout = 1'b1;
              cmd.el_op        = EL_CLEAR;
            end else begin
              cmd.el_op = EL_INC;
            end
          end
          S_WAIT_HIGH: begin
            if (sts.ge_inc) begin
              cmd.push_timeout = 1'b1;
              cmd.el_op        = EL_CLEAR;
            end else if (!feedback_level) begin
              cmd.el_op = EL_INC;
            end else if (sts.ge_one) begin
              cmd.push_timeout = 1'b1;
              cmd.el_op        = EL_CLEAR;
            end else begin
              cmd.el_op = EL_ONE;
            end
          end
          S_MEASURE: begin
            if (!feedback_level) begin
              cmd.div_start = 1'b1;
            end else if (sts.ge_inc) begin
              cmd.push_timeout = 1'b1;
              cmd.el_op        = EL_CLEAR;
            end else begin
              cmd.el_op = EL_INC;
            end
          end
          default: cmd.el_op = EL_HOLD;
        endcase
      end
    end else if (st_r == S_DIV && sts.div_done && sts.q_room) begin
      cmd.push_div = 1'b1;
      cmd.el_op    = EL_CLEAR;
    end
  end

  `PWSM_ASSERT_IMP(a_push_div_done, cmd.push_div, sts.div_done && st_r == S_DIV)
  `PWSM_ASSERT_NXT(a_start_enters_div, cmd.div_start, st_r == S_DIV && !sts.div_done)
  `PWSM_ASSERT_IMP(a_one_push, cmd.push_timeout, !cmd.push_div && !cmd.div_start)

endmodule

// ===== hw/rtl/pwsm_div.sv =====
module pwsm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pwsm_pkg::SpeedW-1:0]   dividend,
  input  logic [pwsm_pkg::TimeoutW-1:0] divisor,
  output logic                          done,
  output logic [pwsm_pkg::SpeedW-1:0]   quotient
);
  import pwsm_pkg::*;

  logic [SpeedW-1:0]   quot_r;
  logic [TimeoutW-1:0] rem_r;
  logic [TimeoutW-1:0] dvs_r;
  logic [DivCntW-1:0]  cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [TimeoutW:0]   trial;
  logic                fits;
  logic [TimeoutW:0]   diff;

  assign trial = {rem_r, quot_r[SpeedW-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == '1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[SpeedW-2:0], fits};
      rem_r  <= fits ? diff[TimeoutW-1:0] : trial[TimeoutW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

// ===== hw/rtl/pwsm_dp.sv =====
module pwsm_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [pwsm_pkg::SpeedW-1:0] cfg_data,
  input  pwsm_pkg::ctl_cmd_t          cmd,
  output pwsm_pkg::ctl_sts_t          sts,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pwsm_pkg::SpeedW-1:0] out_tdata,
  output logic                        out_tuser
);
  import pwsm_pkg::*;

  logic [TimeoutW-1:0] timeout_r;
  logic [SpeedW-1:0]   numer_r;
  logic [TimeoutW-1:0] elapsed_r;
  logic [TimeoutW-1:0] el_inc;
  logic [TimeoutW-1:0] width;
  logic                div_done;
  logic [SpeedW-1:0]   quotient;

  logic [SpeedW:0]     q_mem_r [2];
  logic                q_wp_r;
  logic                q_rp_r;
  logic [1:0]          q_cnt_r;
  logic                push;
  logic                pop;
  logic [SpeedW:0]     push_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TimeoutReset;
      numer_r   <= NumerReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgTimeout: timeout_r <= cfg_data[TimeoutW-1:0];
        CfgNumer:   numer_r   <= cfg_data;
        default:    numer_r   <= numer_r;
      endcase
    end
  end

  assign el_inc = (elapsed_r == ElapsedMax) ? elapsed_r : elapsed_r + 1'b1;
  assign width  = (elapsed_r == '0) ? TimeoutW'(1) : elapsed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else begin
      unique case (cmd.el_op)
        EL_HOLD:  elapsed_r <= elapsed_r;
        EL_CLEAR: elapsed_r <= '0;
        EL_INC:   elapsed_r <= el_inc;
        EL_ONE:   elapsed_r <= TimeoutW'(1);
        default:  elapsed_r <= elapsed_r;
      endcase
    end
  end

  pwsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (numer_r),
    .divisor  (width),
    .done     (div_done),
    .quotient (quotient)
  );

  assign push      = cmd.push_timeout || cmd.push_div;
  assign pop       = out_tvalid && out_tready;
  assign push_data = cmd.push_div ? {1'b0, quotient} : {1'b1, {SpeedW{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= '0;
    end else begin
      if (push) begin
        q_wp_r <= ~q_wp_r;
      end
      if (pop) begin
        q_rp_r <= ~q_rp_r;
      end
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[q_wp_r] <= push_data;
    end
  end

  assign out_tvalid = (q_cnt_r != '0);
  assign out_tdata  = q_mem_r[q_rp_r][SpeedW-1:0];
  assign out_tuser  = q_mem_r[q_rp_r][SpeedW];

  assign sts.ge_inc   = el_inc >= timeout_r;
  assign sts.ge_one   = timeout_r <= TimeoutW'(1);
  assign sts.div_done = div_done;
  assign sts.q_room   = (q_cnt_r != 2'd2);

endmodule

// ===== hw/rtl/pulse_width_speed_meter.sv =====
// A timeout result is queued when its tick is accepted; a two-word output queue
// holds results while ticks go on. A pulse-end tick starts the 32-step radix-2
// divider, whose quotient is queued once done and the queue has room. One tick
// per cycle is taken while the queue has room, except that input is held off from
// the pulse-end tick until its quotient is queued. Synchronous active-low reset
// sets idle, clears the count and queue, loads timeout 5000 and numerator 4000000.
module pulse_width_speed_meter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] start_req, [1] feedback_level, [7:2] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] speed_rps
  output logic        out_tuser,  // [0] timed_out
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import pwsm_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  pwsm_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .start_req      (in_tdata[0]),
    .feedback_level (in_tdata[1]),
    .sts            (sts),
    .cmd            (cmd)
  );

  pwsm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== dv/pulse_width_speed_meter_test.sv =====
module pulse_width_speed_meter_test;
  import pwsm_pkg::*;

  typedef enum logic [1:0] {
    MTR_IDLE,
    MTR_ARMED,
    MTR_SEEK_HIGH,
    MTR_PULSE
  } meter_phase_t;

  typedef struct packed {
    logic [31:0] speed_rps;
    logic        timed_out;
  } reading_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [0] start_req, [1] feedback_level, [7:2] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [31:0] speed_rps
  logic        out_tuser;           // [0] timed_out
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [31:0] cfg_data   = 32'h0;

  meter_phase_t meter_phase   = MTR_IDLE;
  logic [15:0]  window_ticks  = 16'd0;
  logic [15:0]  timeout_limit = TimeoutReset;
  logic [31:0]  speed_numer   = NumerReset;

  reading_t pending_readings[$];
  int errors       = 0;
  int active_ticks = 0;
  int hold_cycles  = 0;
  bit source_gaps  = 1'b1;
  bit sink_gaps    = 1'b1;

  always #5 clk = ~clk;

  pulse_width_speed_meter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic bit tick_window();
    if (window_ticks != ElapsedMax) window_ticks++;
    return window_ticks >= timeout_limit;
  endfunction

  function automatic bit predict_tick(input bit start, input bit level, output reading_t r);
    r = '0;
    if (start) begin
      meter_phase  = MTR_ARMED;
      window_ticks = '0;
      return 1'b0;
    end
    case (meter_phase)
      MTR_ARMED, MTR_SEEK_HIGH: begin
        if (tick_window()) begin
          r.timed_out = 1'b1;
        end else if (meter_phase == MTR_ARMED || !level) begin
          if (!level) meter_phase = MTR_SEEK_HIGH;
          return 1'b0;
        end else begin
          // The rising tick opens a fresh window and counts as the first high tick.
          meter_phase  = MTR_PULSE;
          window_ticks = '0;
          if (!tick_window()) return 1'b0;
          r.timed_out = 1'b1;
        end
      end
      MTR_PULSE: begin
        if (level) begin
          if (!tick_window()) return 1'b0;
          r.timed_out = 1'b1;
        end else begin
          r.speed_rps = speed_numer / ((window_ticks == 16'd0) ? 32'd1 : {16'd0, window_ticks});
        end
      end
      default: return 1'b0;
    endcase
    meter_phase  = MTR_IDLE;
    window_ticks = '0;
    return 1'b1;
  endfunction

  task automatic send_tick(input bit start, input bit level);
    reading_t r;
    if (source_gaps && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, level, start};
    do @(posedge clk); while (!in_tready);
    if (start || meter_phase != MTR_IDLE) active_ticks++;
    if (predict_tick(start, level, r)) pending_readings.push_back(r);
  endtask

  task automatic send_pulse(input int highs_before, input int lows, input int width);
    send_tick(1'b1, 1'($urandom_range(1)));
    repeat (highs_before) send_tick(1'b0, 1'b1);
    repeat (lows) send_tick(1'b0, 1'b0);
    repeat (width) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic drain_readings();
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Brings the meter back to idle so that a register write cannot land mid-measurement.
  task automatic settle_meter();
    int k;
    k = 0;
    while (meter_phase != MTR_IDLE) begin
      send_tick(1'b0, k % 3 == 1);
      k++;
    end
    drain_readings();
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    settle_meter();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgTimeout) timeout_limit = value[15:0];
    else speed_numer = value;
  endtask

  task automatic test_default_registers();
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_pulse(2, 1, 4);
    send_pulse(0, 3, 1);
    send_pulse(1, 2, 250);
    drain_readings();
  endtask

  task automatic test_numerator_extremes();
    write_reg(CfgNumer, 32'hFFFF_FFFF);
    send_pulse(0, 1, 1);
    send_pulse(0, 1, 7);
    write_reg(CfgNumer, 32'd0);
    send_pulse(0, 1, 3);
    write_reg(CfgNumer, 32'd1);
    send_pulse(0, 1, 2);
    send_pulse(0, 1, 1);
    drain_readings();
  endtask

  task automatic test_timeout_limits();
    write_reg(CfgNumer, 32'd1000);
    write_reg(CfgTimeout, 32'd4);
    send_tick(1'b1, 1'b0);
    repeat (4) send_tick(1'b0, 1'b1);
    send_pulse(0, 3, 1);
    send_pulse(0, 2, 3);
    send_pulse(0, 1, 4);
    write_reg(CfgTimeout, 32'd2);
    send_pulse(0, 1, 1);
    write_reg(CfgTimeout, 32'd1);
    send_pulse(0, 1, 1);
    write_reg(CfgTimeout, 32'd0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    drain_readings();
  endtask

  task automatic test_longest_window();
    write_reg(CfgTimeout, 32'd65535);
    source_gaps = 1'b0;
    sink_gaps   = 1'b0;
    send_tick(1'b1, 1'b1);
    repeat (40) send_tick(1'b0, 1'b1);
    send_pulse(5, 5, 60);
    drain_readings();
    source_gaps = 1'b1;
    sink_gaps   = 1'b1;
  endtask

  task automatic test_restart();
    write_reg(CfgTimeout, 32'd50);
    write_reg(CfgNumer, 32'd1000000);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    repeat (3) send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    repeat (2) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    drain_readings();
  endtask

  task automatic test_output_stall();
    write_reg(CfgTimeout, 32'd1);
    hold_cycles = 300;
    repeat (40) begin
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
    end
    drain_readings();
    write_reg(CfgTimeout, 32'd20);
    hold_cycles = 200;
    repeat (10) send_pulse(0, 1, 2);
    drain_readings();
  endtask

  task automatic test_random_traffic();
    int burst;
    int lim;
    int pick;
    int target;
    for (burst = 0; burst < 6; burst++) begin
      case (burst)
        0: write_reg(CfgTimeout, 32'd1);
        1: write_reg(CfgTimeout, $urandom_range(3, 12));
        2: write_reg(CfgTimeout, 32'd65535);
        default: write_reg(CfgTimeout, $urandom_range(13, 60));
      endcase
      case (burst)
        1: write_reg(CfgNumer, 32'd1);
        3: write_reg(CfgNumer, 32'hFFFF_FFFF);
        default: write_reg(CfgNumer, $urandom);
      endcase
      source_gaps = (burst != 4);
      sink_gaps   = (burst != 4);
      target = active_ticks + 60;
      while (active_ticks < target) begin
        lim  = (int'(timeout_limit) > 40) ? 40 : int'(timeout_limit) + 1;
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_pulse($urandom_range(3), $urandom_range(1, 3), $urandom_range(1, lim));
        end else if (pick < 85) begin
          send_tick(1'b1, 1'($urandom_range(1)));
          repeat ($urandom_range(1, 4)) send_tick(1'b0, 1'($urandom_range(1)));
        end else begin
          repeat ($urandom_range(1, 6)) send_tick($urandom_range(99) < 20, 1'($urandom_range(1)));
        end
      end
    end
    source_gaps = 1'b1;
    sink_gaps   = 1'b1;
    drain_readings();
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        out_tready <= !sink_gaps || ($urandom_range(99) >= 10);
      end
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual speed %0d timed_out %0b",
                 $time, out_tdata, out_tuser);
      end else begin
        want = pending_readings.pop_front();
        if (out_tdata !== want.speed_rps) begin
          errors++;
          $display("%0t: speed_rps expected %0d actual %0d", $time, want.speed_rps, out_tdata);
        end
        if (out_tuser !== want.timed_out) begin
          errors++;
          $display("%0t: timed_out expected %0b actual %0b", $time, want.timed_out, out_tuser);
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_registers();
    test_numerator_extremes();
    test_timeout_limits();
    test_restart();
    test_output_stall();
    test_longest_window();
    test_random_traffic();
    drain_readings();
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("pulse_width_speed_meter_test OK");
    end else begin
      $display("pulse_width_speed_meter_test NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("pulse_width_speed_meter_test NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pwsm_pkg.sv
hw/rtl/pwsm_ctrl.sv
hw/rtl/pwsm_div.sv
hw/rtl/pwsm_dp.sv
hw/rtl/pulse_width_speed_meter.sv
dv/pulse_width_speed_meter_test.sv
